// File: sv/ocs_to_wcs_corner_transform_unit_defines.svh
// assertion macros for the ocs to wcs corner transform unit
// used by the checker module, needs clk and rst_n in scope
`ifndef OCS_TO_WCS_CORNER_TRANSFORM_UNIT_DEFINES_SVH
`define OCS_TO_WCS_CORNER_TRANSFORM_UNIT_DEFINES_SVH

// plain property, checked outside reset
`define OCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ocs transform check failed");

// same-cycle implication
`define OCS_ASSERT_IMPL(lbl, ante, cons) \
  `OCS_ASSERT(lbl, (ante) |-> (cons))

`endif

// File: sv/ocs_pkg.sv
// shared types, constants and step functions of the corner transform
// no dependencies
package ocs_pkg;

  localparam int FRAC_N       = 30;
  localparam int SQRT_STAGES  = 16;
  localparam int DIV_STEPS    = 4;
  localparam int DIV_STAGES   = 8;

  typedef logic signed [33:0] vec_t;
  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } sqrt_st_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
  } div_st_t;

  typedef struct packed {
    logic [1:0]         slot;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] n0;
    logic signed [31:0] n1;
    logic signed [31:0] n2;
  } side1_t;

  typedef struct packed {
    side1_t base;
    logic   deg;
    unit_t  a0;
    unit_t  a1;
    unit_t  a2;
  } side2_t;

  function automatic logic [33:0] mag34(vec_t v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  // one digit of the floor square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [63:0] bitv);
    sqrt_st_t o;
    logic [63:0] t;
    t = s.res + bitv;
    if (s.x >= t) begin
      o.x   = s.x - t;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // one restoring division step
  function automatic div_st_t div_step(div_st_t s, logic dbit, logic [31:0] len);
    div_st_t o;
    logic [32:0] t;
    t = {s.rem, dbit};
    if (t >= {1'b0, len}) begin
      o.rem = 32'(t - {1'b0, len});
      o.q   = {s.q[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.q   = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: sv/ocs_norm.sv
// pipelined vector normaliser: squares, floor sqrt, three dividers, clamp
// depends on ocs_pkg
module ocs_norm import ocs_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  vec_t              in_v [3],
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output unit_t             out_u [3],
  output logic              out_zero,
  output logic [SIDE_W-1:0] out_side
);

  localparam int L    = SQRT_STAGES + DIV_STAGES + 4;
  localparam int ST_D = SQRT_STAGES + 2;

  logic [L-1:0]      vld_r;
  vec_t              v_r [L-1][3];
  logic [SIDE_W-1:0] side_r [L];

  logic [63:0] sq_nxt [3];
  logic [63:0] sq_r [3];
  logic [63:0] sum_r;
  sqrt_st_t    sqst_r [SQRT_STAGES];
  logic [63:0] d_r [3];
  logic [31:0] len_r;
  div_st_t     dst_r [DIV_STAGES][3];
  logic [63:0] dp_r [DIV_STAGES][3];
  logic [31:0] lenp_r [DIV_STAGES];
  logic [2:0]  ovf_r [DIV_STAGES];
  unit_t       u_r [3];
  logic        zero_r;

  // valid and passenger pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= in_v;
      side_r[0] <= in_side;
      for (int k = 1; k < L - 1; k++) v_r[k] <= v_r[k-1];
      for (int k = 1; k < L; k++) side_r[k] <= side_r[k-1];
    end
  end

  // squares, truncated to 64 bits
  always_comb begin
    logic [67:0] p;
    logic [33:0] a;
    for (int i = 0; i < 3; i++) begin
      a = mag34(in_v[i]);
      p = {34'd0, a} * {34'd0, a};
      sq_nxt[i] = p[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_nxt;
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // floor square root, two digits a stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam int B1 = 31 - 2 * k;
    localparam int B2 = 30 - 2 * k;
    sqrt_st_t st_in, st_mid, st_nxt;
    if (k == 0) begin : g_first
      assign st_in = '{x: sum_r, res: 64'd0};
    end else begin : g_next
      assign st_in = sqst_r[k-1];
    end
    assign st_mid = sqrt_step(st_in, 64'd1 << (2 * B1));
    assign st_nxt = sqrt_step(st_mid, 64'd1 << (2 * B2));
    always_ff @(posedge clk) begin
      if (en) sqst_r[k] <= st_nxt;
    end
  end

  // rounded dividends
  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= sqst_r[SQRT_STAGES-1].res[31:0];
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= {mag34(v_r[ST_D-1][i]), 30'd0}
                  + {33'd0, sqst_r[SQRT_STAGES-1].res[31:1]};
      end
    end
  end

  // quotient, four bits a stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_st_t     st_in [3];
    div_st_t     st_nxt [3];
    logic [63:0] d_in [3];
    logic [31:0] len_in;
    logic [2:0]  ovf_in;
    if (k == 0) begin : g_first
      always_comb begin
        len_in = len_r;
        for (int i = 0; i < 3; i++) begin
          d_in[i]      = d_r[i];
          st_in[i].rem = d_r[i][63:32];
          st_in[i].q   = 32'd0;
          ovf_in[i]    = d_r[i][63:32] >= len_r;
        end
      end
    end else begin : g_next
      assign len_in = lenp_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign d_in   = dp_r[k-1];
      assign st_in  = dst_r[k-1];
    end
    always_comb begin
      div_st_t s;
      for (int i = 0; i < 3; i++) begin
        s = st_in[i];
        for (int j = 0; j < DIV_STEPS; j++) begin
          s = div_step(s, d_in[i][31 - DIV_STEPS * k - j], len_in);
        end
        st_nxt[i] = s;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dst_r[k]  <= st_nxt;
        dp_r[k]   <= d_in;
        lenp_r[k] <= len_in;
        ovf_r[k]  <= ovf_in;
      end
    end
  end

  // clamp to one and restore sign
  always_ff @(posedge clk) begin
    logic [31:0] q;
    logic [31:0] m;
    if (en) begin
      zero_r <= lenp_r[DIV_STAGES-1] == 32'd0;
      for (int i = 0; i < 3; i++) begin
        q = dst_r[DIV_STAGES-1][i].q;
        if (ovf_r[DIV_STAGES-1][i] || q > (32'd1 << FRAC_N)) begin
          m = 32'd1 << FRAC_N;
        end else begin
          m = q;
        end
        u_r[i] <= v_r[L-2][i][33] ? -$signed(m) : $signed(m);
      end
    end
  end

  assign out_vld  = vld_r[L-1];
  assign out_u    = u_r;
  assign out_zero = zero_r;
  assign out_side = side_r[L-1];

endmodule

// File: sv/ocs_to_wcs_corner_transform_unit.sv
// throughput: one transaction per cycle; the pipeline advances as a whole and
//   holds only while a finished result waits on out_stall
// reset: rst_n low clears every stage valid and the output valid; data
//   registers keep what they hold
// depends on ocs_pkg and ocs_norm
module ocs_to_wcs_corner_transform_unit import ocs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_corner_index,
  input  logic signed [31:0] in_corner_x,
  input  logic signed [31:0] in_corner_y,
  input  logic signed [31:0] in_corner_z,
  input  logic signed [31:0] in_ext_x,
  input  logic signed [31:0] in_ext_y,
  input  logic signed [31:0] in_ext_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_slot,
  output logic signed [31:0] out_world_x,
  output logic signed [31:0] out_world_y,
  output logic signed [31:0] out_world_z,
  output logic               out_degenerate,
  output logic               out_saturated
);

  // threshold 1/64 in q2.30
  localparam logic [32:0]        SMALL_LIMIT = 33'd1 << 24;
  localparam logic signed [63:0] HALF_N      = 64'sd1 <<< (FRAC_N - 1);
  localparam logic signed [35:0] W_MAX       = 36'sd2147483647;
  localparam logic signed [35:0] W_MIN       = -36'sd2147483648;

  // whole pipeline moves unless a result is held at the output
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 0: arbitrary-axis choice
  logic       s0_vld_r;
  vec_t       ax_nxt [3];
  vec_t       ax_r [3];
  side1_t     s0_side_nxt;
  side1_t     s0_side_r;
  logic [32:0] abs_nx, abs_ny;

  assign abs_nx = in_ext_x[31] ? 33'(-{in_ext_x[31], in_ext_x}) : {1'b0, in_ext_x};
  assign abs_ny = in_ext_y[31] ? 33'(-{in_ext_y[31], in_ext_y}) : {1'b0, in_ext_y};

  always_comb begin
    if (abs_nx < SMALL_LIMIT && abs_ny < SMALL_LIMIT) begin
      // near the world z axis: ax = (nz, 0, -nx)
      ax_nxt[0] = 34'(in_ext_z);
      ax_nxt[1] = '0;
      ax_nxt[2] = -34'(in_ext_x);
    end else begin
      // ax = (-ny, nx, 0)
      ax_nxt[0] = -34'(in_ext_y);
      ax_nxt[1] = 34'(in_ext_x);
      ax_nxt[2] = '0;
    end
    // corners 2 and 3 trade slots
    case (in_corner_index)
      2'd2:    s0_side_nxt.slot = 2'd3;
      2'd3:    s0_side_nxt.slot = 2'd2;
      default: s0_side_nxt.slot = in_corner_index;
    endcase
    s0_side_nxt.c0 = in_corner_x;
    s0_side_nxt.c1 = in_corner_y;
    s0_side_nxt.c2 = in_corner_z;
    s0_side_nxt.n0 = in_ext_x;
    s0_side_nxt.n1 = in_ext_y;
    s0_side_nxt.n2 = in_ext_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= ax_nxt;
      s0_side_r <= s0_side_nxt;
    end
  end

  // normalise ax
  logic                      n1_vld;
  unit_t                     n1_u [3];
  logic                      n1_zero;
  logic [$bits(side1_t)-1:0] n1_side_vec;
  side1_t                    n1_side;

  ocs_norm #(.SIDE_W($bits(side1_t))) u_norm_ax (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s0_vld_r),
    .in_v     (ax_r),
    .in_side  (s0_side_r),
    .out_vld  (n1_vld),
    .out_u    (n1_u),
    .out_zero (n1_zero),
    .out_side (n1_side_vec)
  );
  assign n1_side = n1_side_vec;

  // cross product n x ax: products, then difference with rounding
  logic               x1_vld_r, x2_vld_r;
  logic signed [63:0] xp_r [6];
  side2_t             x1_side_r, x2_side_r;
  vec_t               ay_r [3];
  logic signed [63:0] xs [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= n1_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0] <= n1_side.n1 * n1_u[2];
      xp_r[1] <= n1_side.n2 * n1_u[1];
      xp_r[2] <= n1_side.n2 * n1_u[0];
      xp_r[3] <= n1_side.n0 * n1_u[2];
      xp_r[4] <= n1_side.n0 * n1_u[1];
      xp_r[5] <= n1_side.n1 * n1_u[0];
      x1_side_r.base <= n1_side;
      x1_side_r.deg  <= n1_zero;
      x1_side_r.a0   <= n1_u[0];
      x1_side_r.a1   <= n1_u[1];
      x1_side_r.a2   <= n1_u[2];
    end
  end

  // round half up to q2.30 (floor of value plus one half)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = xp_r[2*i] - xp_r[2*i+1] + HALF_N;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) ay_r[i] <= xs[i][63:30];
      x2_side_r <= x1_side_r;
    end
  end

  // normalise ay
  logic                      n2_vld;
  unit_t                     n2_u [3];
  logic                      n2_zero;
  logic [$bits(side2_t)-1:0] n2_side_vec;
  side2_t                    n2_side;

  ocs_norm #(.SIDE_W($bits(side2_t))) u_norm_ay (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (x2_vld_r),
    .in_v     (ay_r),
    .in_side  (x2_side_r),
    .out_vld  (n2_vld),
    .out_u    (n2_u),
    .out_zero (n2_zero),
    .out_side (n2_side_vec)
  );
  assign n2_side = n2_side_vec;

  // world point: x*ax + y*ay + z*n, exact in q18.46
  logic               w1_vld_r, w2_vld_r;
  logic signed [63:0] wp_r [3][3];
  logic [1:0]         w1_slot_r, w2_slot_r;
  logic               w1_deg_r, w2_deg_r;
  logic signed [65:0] ws [3];
  logic signed [35:0] w_r [3];
  unit_t              a_u [3];
  logic signed [31:0] n_v [3];

  assign a_u[0] = n2_side.a0;
  assign a_u[1] = n2_side.a1;
  assign a_u[2] = n2_side.a2;
  assign n_v[0] = n2_side.base.n0;
  assign n_v[1] = n2_side.base.n1;
  assign n_v[2] = n2_side.base.n2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_vld_r <= 1'b0;
      w2_vld_r <= 1'b0;
    end else if (en) begin
      w1_vld_r <= n2_vld;
      w2_vld_r <= w1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        wp_r[i][0] <= n2_side.base.c0 * a_u[i];
        wp_r[i][1] <= n2_side.base.c1 * n2_u[i];
        wp_r[i][2] <= n2_side.base.c2 * n_v[i];
      end
      w1_slot_r <= n2_side.base.slot;
      w1_deg_r  <= n2_side.deg || n2_zero;
    end
  end

  // round half up to q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ws[i] = wp_r[i][0] + wp_r[i][1] + wp_r[i][2] + HALF_N;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) w_r[i] <= ws[i][65:30];
      w2_slot_r <= w1_slot_r;
      w2_deg_r  <= w1_deg_r;
    end
  end

  // output register: clamp, degenerate override
  logic               out_valid_r;
  logic [1:0]         out_slot_r;
  logic signed [31:0] out_w_r [3];
  logic               out_deg_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= w2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic sat;
    if (en) begin
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (w2_deg_r) begin
          out_w_r[i] <= '0;
        end else if (w_r[i] > W_MAX) begin
          out_w_r[i] <= W_MAX[31:0];
          sat = 1'b1;
        end else if (w_r[i] < W_MIN) begin
          out_w_r[i] <= W_MIN[31:0];
          sat = 1'b1;
        end else begin
          out_w_r[i] <= w_r[i][31:0];
        end
      end
      out_slot_r <= w2_slot_r;
      out_deg_r  <= w2_deg_r;
      out_sat_r  <= sat && !w2_deg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_world_x    = out_w_r[0];
  assign out_world_y    = out_w_r[1];
  assign out_world_z    = out_w_r[2];
  assign out_degenerate = out_deg_r;
  assign out_saturated  = out_sat_r;

endmodule

// File: sv/ocs_chk.sv
// port-level checker for the corner transform, bound to the top level
// depends on ocs_to_wcs_corner_transform_unit_defines.svh
`include "ocs_to_wcs_corner_transform_unit_defines.svh"

module ocs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_world_x,
  input logic signed [31:0] out_world_y,
  input logic signed [31:0] out_world_z,
  input logic               out_degenerate,
  input logic               out_saturated
);

  logic all_zero;
  logic any_end;

  assign all_zero = out_world_x == 32'sd0 && out_world_y == 32'sd0 && out_world_z == 32'sd0;
  assign any_end  = out_world_x == 32'sh7fffffff || out_world_x == 32'sh80000000
                 || out_world_y == 32'sh7fffffff || out_world_y == 32'sh80000000
                 || out_world_z == 32'sh7fffffff || out_world_z == 32'sh80000000;

  // held result stays offered
  `OCS_ASSERT(a_hold, (out_valid && out_stall) |=> out_valid)
  // input side only stalls behind a held result
  `OCS_ASSERT_IMPL(a_stall_src, in_stall, out_valid && out_stall)
  // degenerate transaction carries zeros and no saturation
  `OCS_ASSERT_IMPL(a_deg_zero, out_valid && out_degenerate, all_zero && !out_saturated)
  // saturation shows a clamped coordinate
  `OCS_ASSERT_IMPL(a_sat_end, out_valid && out_saturated, any_end)

endmodule

bind ocs_to_wcs_corner_transform_unit ocs_chk u_ocs_chk (.*);

// File: verif/ocs_transform_checker.sv
// checker for the corner transform unit: watches both channels, predicts
// each world-space corner and compares it with the block's transaction
// depends on nothing but the port widths of ocs_to_wcs_corner_transform_unit
`timescale 1ns / 100ps

module ocs_transform_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_corner_index,
  input  logic signed [31:0] in_corner_x,
  input  logic signed [31:0] in_corner_y,
  input  logic signed [31:0] in_corner_z,
  input  logic signed [31:0] in_ext_x,
  input  logic signed [31:0] in_ext_y,
  input  logic signed [31:0] in_ext_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_slot,
  input  logic signed [31:0] out_world_x,
  input  logic signed [31:0] out_world_y,
  input  logic signed [31:0] out_world_z,
  input  logic               out_degenerate,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]         slot;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               deg;
    logic               sat;
  } world_pt_t;

  localparam longint SMALL_N = 64'sd1 << 24;
  localparam longint HALF_N  = 64'sd1 << 29;

  world_pt_t world_q[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // unit vector in Q2.30; sum of squares wraps at 64 bits like the datapath
  function automatic logic to_unit(input longint v[3], output longint u[3]);
    logic [63:0] sq_sum;
    logic [63:0] len;
    logic [63:0] mag;
    logic [63:0] q;
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sq_sum = sq_sum + mag * mag;
    end
    len = floor_sqrt(sq_sum);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      q = ((mag << 30) + (len >> 1)) / len;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic world_pt_t transform_corner(logic [1:0] idx, longint c[3],
                                                 longint n[3]);
    world_pt_t r;
    longint ax[3], axu[3], ay[3], ayu[3];
    logic signed [127:0] acc;
    logic signed [31:0] w[3];
    r = '0;
    r.slot = (idx == 2'd2) ? 2'd3 : (idx == 2'd3) ? 2'd2 : idx;
    // arbitrary-axis rule: near the world z axis use world y as the helper
    if ((n[0] < SMALL_N && n[0] > -SMALL_N) && (n[1] < SMALL_N && n[1] > -SMALL_N)) begin
      ax[0] = n[2]; ax[1] = 0; ax[2] = -n[0];
    end else begin
      ax[0] = -n[1]; ax[1] = n[0]; ax[2] = 0;
    end
    if (!to_unit(ax, axu)) begin
      r.deg = 1'b1;
      return r;
    end
    ay[0] = (n[1] * axu[2] - n[2] * axu[1] + HALF_N) >>> 30;
    ay[1] = (n[2] * axu[0] - n[0] * axu[2] + HALF_N) >>> 30;
    ay[2] = (n[0] * axu[1] - n[1] * axu[0] + HALF_N) >>> 30;
    if (!to_unit(ay, ayu)) begin
      r.deg = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 128'(c[0] * axu[i]) + 128'(c[1] * ayu[i]) + 128'(c[2] * n[i]) + 128'(HALF_N);
      acc = acc >>> 30;
      if (acc > 128'sd2147483647) begin
        w[i] = 32'sh7fffffff; r.sat = 1'b1;
      end else if (acc < -128'sd2147483648) begin
        w[i] = 32'sh80000000; r.sat = 1'b1;
      end else begin
        w[i] = acc[31:0];
      end
    end
    r.wx = w[0]; r.wy = w[1]; r.wz = w[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    world_pt_t want;
    longint c[3], n[3];
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (world_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = world_q.pop_front();
          if (out_slot != want.slot) report_mismatch("slot", out_slot, want.slot);
          if (out_world_x != want.wx) report_mismatch("world_x", out_world_x, want.wx);
          if (out_world_y != want.wy) report_mismatch("world_y", out_world_y, want.wy);
          if (out_world_z != want.wz) report_mismatch("world_z", out_world_z, want.wz);
          if (out_degenerate != want.deg)
            report_mismatch("degenerate", out_degenerate, want.deg);
          if (out_saturated != want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
        end
      end
      if (in_valid && !in_stall) begin
        c[0] = in_corner_x; c[1] = in_corner_y; c[2] = in_corner_z;
        n[0] = in_ext_x; n[1] = in_ext_y; n[2] = in_ext_z;
        world_q.push_back(transform_corner(in_corner_index, c, n));
      end
      pending <= world_q.size();
    end
  end

endmodule

// File: verif/tb_ocs_to_wcs_corner_transform_unit.sv
// top of the corner transform testbench: clock, reset, corner stimulus,
// random idling on both channels and the verdict
// depends on ocs_to_wcs_corner_transform_unit and ocs_transform_checker
`timescale 1ns / 100ps

module tb_ocs_to_wcs_corner_transform_unit;

  localparam int ONE_N = 32'h40000000;  // 1.0 in Q2.30

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_corner_index;
  logic signed [31:0] in_corner_x, in_corner_y, in_corner_z;
  logic signed [31:0] in_ext_x, in_ext_y, in_ext_z;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_slot;
  logic signed [31:0] out_world_x, out_world_y, out_world_z;
  logic               out_degenerate, out_saturated;
  int                 fail_count;
  int                 pending;

  // idle rates in percent, changed per phase
  int tx_idle_pct;
  int rx_stall_pct;

  ocs_to_wcs_corner_transform_unit uut (.*);

  ocs_transform_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stall per cycle at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // one transaction: optional idle cycles, then hold until accepted
  task automatic send_corner(logic [1:0] idx, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_corner_index <= idx;
    in_corner_x <= cx; in_corner_y <= cy; in_corner_z <= cz;
    in_ext_x <= nx; in_ext_y <= ny; in_ext_z <= nz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random coordinate: mostly moderate, sometimes full 32-bit range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65535 * 200)) - 65535 * 100);
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  // random extrusion component: near-unit, small, around the threshold or raw
  function automatic logic [31:0] rand_ext();
    int sgn;
    sgn = $urandom_range(1) ? -1 : 1;
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'(sgn * int'($urandom_range(16)));
      2: return 32'(sgn * ((1 << 24) + int'($urandom_range(2)) - 1));
      3: return 32'(sgn * int'($urandom_range(1 << 24)));
      default: return 32'(sgn * int'($urandom_range(ONE_N)));
    endcase
  endfunction

  task automatic random_batch(int count);
    logic [31:0] nx, ny, nz;
    for (int i = 0; i < count; i++) begin
      nx = rand_ext(); ny = rand_ext(); nz = rand_ext();
      // a third of the extrusions close to +z or -z, the common drawing case
      if ($urandom_range(2) == 0) begin
        nx = 32'($signed($urandom_range(1 << 25)) - (1 << 24));
        ny = 32'($signed($urandom_range(1 << 25)) - (1 << 24));
        nz = $urandom_range(1) ? ONE_N : -ONE_N;
      end
      send_corner(2'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord(),
                  nx, ny, nz);
    end
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_corner_index = '0;
    in_corner_x = '0; in_corner_y = '0; in_corner_z = '0;
    in_ext_x = '0; in_ext_y = '0; in_ext_z = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every corner index with the plain +z extrusion
    for (int i = 0; i < 4; i++)
      send_corner(2'(i), 32'h00010000 * (i + 1), -32'h00020000, 32'h00008000, 0, 0, ONE_N);
    // degenerate: zero extrusion, and a tiny one on the y axis
    send_corner(2'd0, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0);
    send_corner(2'd3, 32'h00010000, 32'h00010000, 32'h00010000, 0, 1, 0);
    // threshold of the axis rule, both sides and both signs
    send_corner(2'd1, 32'h00010000, 32'h00030000, 32'h00050000, (1 << 24) - 1, 0, ONE_N);
    send_corner(2'd1, 32'h00010000, 32'h00030000, 32'h00050000, 1 << 24, 0, ONE_N);
    send_corner(2'd2, 32'h00010000, 32'h00030000, 32'h00050000, 0, -(1 << 24), ONE_N);
    send_corner(2'd2, 32'h00010000, 32'h00030000, 32'h00050000, 0, -(1 << 24) + 1, -ONE_N);
    // extrusion along x and y, and extreme raw components
    send_corner(2'd0, 32'h00020000, 32'h00030000, 32'h00040000, ONE_N, 0, 0);
    send_corner(2'd1, 32'h00020000, 32'h00030000, 32'h00040000, 0, -ONE_N, 0);
    send_corner(2'd3, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000);
    // overflow to both ends with a non-unit extrusion, then a tiny negative z extrusion
    send_corner(2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff);
    send_corner(2'd2, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff);
    send_corner(2'd3, 32'hffffffff, 32'h00000000, 32'hffffffff, 0, 0, 32'hffffffff);

    // random phases: receiver stalls more, then sender idles more, then none
    tx_idle_pct = 27; rx_stall_pct = 48;
    random_batch(140);
    tx_idle_pct = 48; rx_stall_pct = 27;
    random_batch(130);
    tx_idle_pct = 0; rx_stall_pct = 0;
    random_batch(130);
    in_valid <= 1'b0;

    // drain, then allow the pipeline depth for stray transactions
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/ocs_pkg.sv
sv/ocs_norm.sv
sv/ocs_to_wcs_corner_transform_unit.sv
sv/ocs_chk.sv
verif/ocs_transform_checker.sv
verif/tb_ocs_to_wcs_corner_transform_unit.sv
